@@ hdl/isiadc_pkg.sv @@
package isiadc_pkg;

  // field and datapath widths
  localparam int TapW      = 18;
  localparam int NoiseW    = 18;
  localparam int ResW      = 5;
  localparam int CodeW     = 16;
  localparam int SampleW   = 16;
  localparam int SumW      = 21;
  localparam int NumTapRegs = 6;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  localparam int MaxRes    = 16;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_TAP_0   = 3'd0,
    REG_TAP_1   = 3'd1,
    REG_TAP_2   = 3'd2,
    REG_TAP_3   = 3'd3,
    REG_TAP_4   = 3'd4,
    REG_TAP_5   = 3'd5,
    REG_ADC_RES = 3'd6
  } reg_idx_t;

  typedef logic signed [TapW-1:0] tap_t;
  typedef logic signed [SumW-1:0] sum_t;

  // tap reset values, Q2.15
  localparam tap_t TapReset [NumTapRegs] = '{
    18'sd3932, 18'sd32768, 18'sd18022, 18'sd9175, 18'sd3932, 18'sd1638
  };
  localparam logic [ResW-1:0] ResReset = 5'd8;

  // settings seen by the datapath
  typedef struct packed {
    logic [NumTapRegs-1:0][TapW-1:0] taps;
    logic [ResW-1:0]                 adc_res;
  } cfg_t;

  // tap weighted by a +1/-1 symbol
  function automatic sum_t weigh(input logic [TapW-1:0] t, input logic bit_in);
    sum_t ext;
    ext = sum_t'($signed(t));
    return bit_in ? ext : -ext;
  endfunction

endpackage

@@ hdl/isiadc_regs.sv @@
module isiadc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [isiadc_pkg::AddrW-1:0]   paddr,
  input  logic [isiadc_pkg::DataW-1:0]   pwdata,
  output logic [isiadc_pkg::DataW-1:0]   prdata,
  output isiadc_pkg::cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < isiadc_pkg::NumTapRegs; i++) begin
        cfg.taps[i] <= isiadc_pkg::TapReset[i];
      end
      cfg.adc_res <= isiadc_pkg::ResReset;
    end else if (wr) begin
      case (idx)
        isiadc_pkg::REG_TAP_0:   cfg.taps[0] <= pwdata[isiadc_pkg::TapW-1:0];
        isiadc_pkg::REG_TAP_1:   cfg.taps[1] <= pwdata[isiadc_pkg::TapW-1:0];
        isiadc_pkg::REG_TAP_2:   cfg.taps[2] <= pwdata[isiadc_pkg::TapW-1:0];
        isiadc_pkg::REG_TAP_3:   cfg.taps[3] <= pwdata[isiadc_pkg::TapW-1:0];
        isiadc_pkg::REG_TAP_4:   cfg.taps[4] <= pwdata[isiadc_pkg::TapW-1:0];
        isiadc_pkg::REG_TAP_5:   cfg.taps[5] <= pwdata[isiadc_pkg::TapW-1:0];
        isiadc_pkg::REG_ADC_RES: cfg.adc_res <= pwdata[isiadc_pkg::ResW-1:0];
        default: ;
      endcase
    end
  end

  // taps read back sign extended
  always_comb begin
    case (idx)
      isiadc_pkg::REG_TAP_0:   prdata = 32'($signed(cfg.taps[0]));
      isiadc_pkg::REG_TAP_1:   prdata = 32'($signed(cfg.taps[1]));
      isiadc_pkg::REG_TAP_2:   prdata = 32'($signed(cfg.taps[2]));
      isiadc_pkg::REG_TAP_3:   prdata = 32'($signed(cfg.taps[3]));
      isiadc_pkg::REG_TAP_4:   prdata = 32'($signed(cfg.taps[4]));
      isiadc_pkg::REG_TAP_5:   prdata = 32'($signed(cfg.taps[5]));
      isiadc_pkg::REG_ADC_RES: prdata = 32'(cfg.adc_res);
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ hdl/isiadc_fir.sv @@
module isiadc_fir #(
  parameter int NUM_TAPS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  isiadc_pkg::cfg_t                cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            symbol_bit,
  input  logic [isiadc_pkg::NoiseW-1:0]   noise_sample,
  input  logic                            block_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [isiadc_pkg::SampleW-1:0]  sample
);

  localparam int HistD = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;
  localparam int SampleW_L = isiadc_pkg::SampleW;

  logic [HistD-1:0]      hist;
  logic [HistD-1:0]      hvalid;
  logic [HistD-1:0]      hvalid_eff;
  isiadc_pkg::sum_t      sum;
  logic [SampleW_L-1:0]  clamped;
  logic                  accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // a new block drops all older symbols
  assign hvalid_eff = block_start ? '0 : hvalid;

  always_comb begin
    sum = isiadc_pkg::weigh(cfg.taps[0], symbol_bit)
        + isiadc_pkg::sum_t'($signed(noise_sample));
    for (int k = 1; k < NUM_TAPS; k++) begin
      if (hvalid_eff[k-1]) begin
        sum = sum + isiadc_pkg::weigh(cfg.taps[k], hist[k-1]);
      end
    end
  end

  // saturate to [-1, 1-2^-15], then offset to unsigned
  always_comb begin
    if (sum > isiadc_pkg::sum_t'(32767)) begin
      clamped = 16'hFFFF;
    end else if (sum < isiadc_pkg::sum_t'(-32768)) begin
      clamped = 16'h0000;
    end else begin
      clamped = {~sum[15], sum[14:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hvalid    <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (accept) begin
        for (int i = HistD - 1; i > 0; i--) begin
          hvalid[i] <= hvalid_eff[i-1];
        end
        hvalid[0] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = HistD - 1; i > 0; i--) begin
        hist[i] <= hist[i-1];
      end
      hist[0] <= symbol_bit;
      sample  <= clamped;
    end
  end

endmodule

@@ hdl/isiadc_quant.sv @@
module isiadc_quant (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [isiadc_pkg::ResW-1:0]     adc_res,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [isiadc_pkg::SampleW-1:0]  sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [isiadc_pkg::CodeW-1:0]    code
);

  logic [isiadc_pkg::ResW-1:0]     bits;
  logic [isiadc_pkg::CodeW-1:0]    levels;
  logic [2*isiadc_pkg::CodeW-1:0]  scaled;

  // resolution limited to 1..16
  always_comb begin
    if (adc_res == '0) begin
      bits = 5'd1;
    end else if (adc_res > 5'(isiadc_pkg::MaxRes)) begin
      bits = 5'(isiadc_pkg::MaxRes);
    end else begin
      bits = adc_res;
    end
  end

  assign levels = 16'((17'd1 << bits) - 17'd1);
  // round half up; max sum stays below 2^32
  assign scaled = 32'(sample) * 32'(levels) + 32'h0000_8000;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code <= scaled[31:16];
    end
  end

endmodule

@@ hdl/isi_channel_adc_emulator_core.sv @@
// isi channel emulator with adc quantizer
//
// s_axis carries one symbol per transaction: tdata[0] is the symbol bit
// (0 = -1, 1 = +1), tdata[18:1] the signed q2.15 noise sample, and tuser
// flags the first symbol of a block, which clears the symbol history.
// m_axis returns one adc code per symbol in tdata[15:0], in order.
// taps and adc resolution sit on the apb port; write them only while idle.
//
// a symbol accepted on s_axis is registered in the fir sum and clamp stage,
// then in the multiply/round stage, whose register drives its code on m_axis.
// throughput: one symbol per cycle while m_axis_tready is high; each stage
// moves on whenever the stage behind it is empty or being drained.
//
// reset clears the history, both stage valids and restores the default
// taps and 8-bit resolution. when the receiver stalls, the output holds its
// code and valid; the fir stage takes one more symbol only if it was empty,
// and once both stages are full s_axis_tready drops in the same cycle.
module isi_channel_adc_emulator_core #(
  parameter int NUM_TAPS = 6
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // symbol stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // symbol_bit [0], noise_sample [18:1], zero pad
  input  logic        s_axis_tuser,  // block_start
  // code stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // adc_code
);

  isiadc_pkg::cfg_t                cfg;
  logic                            mid_valid;
  logic                            mid_ready;
  logic [isiadc_pkg::SampleW-1:0]  mid_sample;

  // no wait states
  assign pready = 1'b1;

  isiadc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // tap sum over the current symbol and its history, noise added, clamped
  isiadc_fir #(
    .NUM_TAPS (NUM_TAPS)
  ) u_fir (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .symbol_bit   (s_axis_tdata[0]),
    .noise_sample (s_axis_tdata[18:1]),
    .block_start  (s_axis_tuser),
    .out_valid    (mid_valid),
    .out_ready    (mid_ready),
    .sample       (mid_sample)
  );

  // scale to 2^b-1 levels with round half up
  isiadc_quant u_quant (
    .clk       (clk),
    .rst       (rst),
    .adc_res   (cfg.adc_res),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .sample    (mid_sample),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .code      (m_axis_tdata)
  );

endmodule
